### hdl/mmd_pkg.sv
package mmd_pkg;

    localparam int unsigned COUNT_W         = 11;
    localparam int unsigned MODE_W          = 2;
    localparam int unsigned KV_W            = 32;
    localparam int unsigned SUM_W           = 64;
    localparam int unsigned DEN_W           = 2 * COUNT_W;
    localparam int unsigned STAT_W          = 48;
    localparam int unsigned CFG_IDX_W       = 2;
    localparam int unsigned QUEUE_DEPTH     = 2;
    localparam int unsigned MAX_SAMPLES_DEF = 1024;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STATISTIC_MODE = 2'd2;

    localparam logic [MODE_W-1:0] MODE_BIASED     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UNBIASED   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_INCOMPLETE = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd2;

    typedef struct packed {
        logic [SUM_W-1:0] first_block;
        logic [SUM_W-1:0] second_block;
        logic [SUM_W-1:0] cross_block;
        logic [SUM_W-1:0] first_diag;
        logic [SUM_W-1:0] second_diag;
        logic [SUM_W-1:0] cross_diag;
    } t_sums;

    // One finished set, as handed from the accumulators to the normalizer.
    typedef struct packed {
        t_sums              sums;
        logic [COUNT_W-1:0] nx;
        logic [COUNT_W-1:0] ny;
        logic [MODE_W-1:0]  mode;
    } t_set;

    typedef struct packed {
        logic                    start;
        logic signed [SUM_W-1:0] numer;
        logic [DEN_W-1:0]        denom;
    } t_div_req;

    typedef struct packed {
        logic                    done;
        logic signed [SUM_W-1:0] quot;
    } t_div_rsp;

    function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] c,
                                                      input int unsigned max_samples);
        logic [COUNT_W-1:0] result;
        if (c < COUNT_RESET) begin
            result = COUNT_RESET;
        end else if (32'(c) > max_samples) begin
            result = COUNT_W'(max_samples);
        end else begin
            result = c;
        end
        return result;
    endfunction

endpackage

### hdl/mmd_front.sv
module mmd_front #(
    parameter int unsigned MAX_SAMPLES = mmd_pkg::MAX_SAMPLES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    output logic                             o_busy,
    input  logic signed [mmd_pkg::KV_W-1:0]  i_kernel_value,
    input  logic [mmd_pkg::COUNT_W-1:0]      i_row_position,
    input  logic [mmd_pkg::COUNT_W-1:0]      i_col_position,
    input  logic                             i_final_entry,
    input  logic [mmd_pkg::COUNT_W-1:0]      i_first_count,
    input  logic [mmd_pkg::COUNT_W-1:0]      i_second_count,
    input  logic [mmd_pkg::MODE_W-1:0]       i_mode,
    output logic                             o_push,
    output mmd_pkg::t_set                    o_set,
    input  logic                             i_pop
);

    localparam int unsigned CREDIT_W = $clog2(mmd_pkg::QUEUE_DEPTH + 1);

    logic [mmd_pkg::COUNT_W-1:0] nx;
    logic [mmd_pkg::COUNT_W-1:0] ny;
    logic                        accept;
    logic                        in_first;
    logic                        in_second;
    logic                        in_cross;
    logic                        on_diag;
    logic                        on_cross_diag;

    logic                             r_in_valid;
    logic                             r_sel_first;
    logic                             r_sel_second;
    logic                             r_sel_cross;
    logic                             r_diag;
    logic                             r_cross_diag;
    logic                             r_final;
    logic signed [mmd_pkg::KV_W-1:0]  r_kv;
    logic [mmd_pkg::COUNT_W-1:0]      r_nx;
    logic [mmd_pkg::COUNT_W-1:0]      r_ny;
    logic [mmd_pkg::MODE_W-1:0]       r_mode;
    mmd_pkg::t_sums                   r_sums;
    mmd_pkg::t_sums                   n_sums;
    logic [CREDIT_W-1:0]              r_credit;
    logic [CREDIT_W-1:0]              n_credit;
    logic [mmd_pkg::SUM_W-1:0]        kv_ext;

    assign nx = mmd_pkg::clamp_count(i_first_count, MAX_SAMPLES);
    assign ny = mmd_pkg::clamp_count(i_second_count, MAX_SAMPLES);

    // A credit is held for every final entry until the back end takes its set,
    // so the queue can never overflow.
    assign o_busy = (r_credit == CREDIT_W'(mmd_pkg::QUEUE_DEPTH));
    assign accept = i_start && !o_busy;

    assign in_first  = (i_row_position < nx) && (i_col_position < nx) &&
                       (i_row_position <= i_col_position);
    assign in_second = (i_row_position >= nx) && (i_col_position >= nx) &&
                       (i_row_position <= i_col_position);
    assign in_cross  = (i_row_position >= nx) && (i_col_position < nx);
    assign on_diag       = (i_row_position == i_col_position);
    assign on_cross_diag = ((i_row_position - nx) == i_col_position);

    assign kv_ext = {{(mmd_pkg::SUM_W - mmd_pkg::KV_W){r_kv[mmd_pkg::KV_W-1]}}, r_kv};

    always_comb begin
        n_sums = r_sums;
        if (r_in_valid && r_sel_first) begin
            n_sums.first_block = r_sums.first_block + kv_ext;
            if (r_diag) begin
                n_sums.first_diag = r_sums.first_diag + kv_ext;
            end
        end
        if (r_in_valid && r_sel_second) begin
            n_sums.second_block = r_sums.second_block + kv_ext;
            if (r_diag) begin
                n_sums.second_diag = r_sums.second_diag + kv_ext;
            end
        end
        if (r_in_valid && r_sel_cross) begin
            n_sums.cross_block = r_sums.cross_block + kv_ext;
            if (r_cross_diag) begin
                n_sums.cross_diag = r_sums.cross_diag + kv_ext;
            end
        end
    end

    always_comb begin
        n_credit = r_credit;
        if (accept && i_final_entry && !i_pop) begin
            n_credit = r_credit + 1'b1;
        end else if (i_pop && !(accept && i_final_entry)) begin
            n_credit = r_credit - 1'b1;
        end
    end

    assign o_push     = r_in_valid && r_final;
    assign o_set.sums = n_sums;
    assign o_set.nx   = r_nx;
    assign o_set.ny   = r_ny;
    assign o_set.mode = r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_credit   <= '0;
            r_sums     <= '0;
        end else begin
            r_in_valid <= accept;
            r_credit   <= n_credit;
            if (o_push) begin
                r_sums <= '0;
            end else begin
                r_sums <= n_sums;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sel_first  <= in_first;
            r_sel_second <= in_second;
            r_sel_cross  <= in_cross;
            r_diag       <= on_diag;
            r_cross_diag <= on_cross_diag;
            r_final      <= i_final_entry;
            r_kv         <= i_kernel_value;
            r_nx         <= nx;
            r_ny         <= ny;
            r_mode       <= i_mode;
        end
    end

endmodule

### hdl/mmd_queue.sv
module mmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mmd_pkg::t_set i_wr_data,
    input  logic          i_pop,
    output mmd_pkg::t_set o_rd_data,
    output logic          o_empty
);

    localparam int unsigned PTR_W = (mmd_pkg::QUEUE_DEPTH > 1) ?
                                    $clog2(mmd_pkg::QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(mmd_pkg::QUEUE_DEPTH + 1);

    mmd_pkg::t_set    r_mem [mmd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(mmd_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(mmd_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

### hdl/mmd_divider.sv
module mmd_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mmd_pkg::t_div_req i_req,
    output mmd_pkg::t_div_rsp o_rsp
);

    localparam int unsigned W     = mmd_pkg::SUM_W;
    localparam int unsigned DW    = mmd_pkg::DEN_W;
    localparam int unsigned CNT_W = $clog2(W);

    typedef enum logic [1:0] {
        D_IDLE,
        D_RUN,
        D_FIX
    } t_state;

    t_state           r_state;
    logic             r_neg;
    logic [W-1:0]     r_work;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [W-1:0]     r_quot;
    logic [DW:0]      trial;
    logic             fits;

    // Restoring division on the magnitude, one quotient bit per cycle; the
    // sign goes back on at the end, so the quotient truncates toward zero.
    assign trial = {r_rem, r_work[W-1]};
    assign fits  = (trial >= {1'b0, r_den});

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == D_FIX);
            case (r_state)
                D_IDLE: begin
                    if (i_req.start) begin
                        r_neg   <= i_req.numer[W-1];
                        r_work  <= i_req.numer[W-1] ? W'(-i_req.numer) : i_req.numer;
                        r_rem   <= '0;
                        r_den   <= i_req.denom;
                        r_cnt   <= '0;
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    r_rem  <= fits ? DW'(trial - {1'b0, r_den}) : trial[DW-1:0];
                    r_work <= {r_work[W-2:0], fits};
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(W - 1)) begin
                        r_state <= D_FIX;
                    end
                end
                D_FIX: begin
                    r_quot  <= r_neg ? (~r_work + 1'b1) : r_work;
                    r_state <= D_IDLE;
                end
                default: begin
                    r_state <= D_IDLE;
                end
            endcase
        end
    end

endmodule

### hdl/mmd_back.sv
module mmd_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_empty,
    input  mmd_pkg::t_set                     i_set,
    output logic                              o_pop,
    output mmd_pkg::t_div_req                 o_div_req,
    input  mmd_pkg::t_div_rsp                 i_div_rsp,
    output logic                              o_valid,
    output logic signed [mmd_pkg::STAT_W-1:0] o_statistic,
    output logic                              o_saturated
);

    localparam int unsigned W  = mmd_pkg::SUM_W;
    localparam int unsigned DW = mmd_pkg::DEN_W;
    localparam int unsigned CW = mmd_pkg::COUNT_W;
    localparam int unsigned SW = mmd_pkg::STAT_W;

    localparam logic signed [W+1:0] STAT_MAX = (W+2)'((66'sd1 <<< (SW - 1)) - 66'sd1);
    localparam logic signed [W+1:0] STAT_MIN = (W+2)'(-(66'sd1 <<< (SW - 1)));
    localparam logic [SW-1:0]       SAT_POS  = {1'b0, {(SW - 1){1'b1}}};
    localparam logic [SW-1:0]       SAT_NEG  = {1'b1, {(SW - 1){1'b0}}};

    typedef enum logic [3:0] {
        B_IDLE,
        B_PREP,
        B_NUM,
        B_DIV_A,
        B_DIV_B,
        B_DIV_C,
        B_SUM,
        B_DIFF,
        B_SAT
    } t_state;

    t_state                r_state;
    mmd_pkg::t_set         r_set;
    logic [W-1:0]          r_ta;
    logic [W-1:0]          r_tb;
    logic [W-1:0]          r_tc;
    logic [DW-1:0]         r_den_a;
    logic [DW-1:0]         r_den_b;
    logic [DW-1:0]         r_den_c;
    logic [W-1:0]          r_num_a;
    logic [W-1:0]          r_num_b;
    logic [W-1:0]          r_num_c;
    logic                  r_div_start;
    logic signed [W-1:0]   r_qa;
    logic signed [W-1:0]   r_qb;
    logic signed [W-1:0]   r_qc;
    logic signed [W:0]     r_sum;
    logic signed [W+1:0]   r_diff;

    logic                  biased;
    logic                  incomplete;
    logic [CW-1:0]         fa;
    logic [CW-1:0]         fb;
    logic [CW-1:0]         fc;
    logic                  sat_hi;
    logic                  sat_lo;

    assign biased     = (r_set.mode == mmd_pkg::MODE_BIASED);
    assign incomplete = (r_set.mode == mmd_pkg::MODE_INCOMPLETE);

    // Second factor of each denominator; the first is always nx, ny or nx respectively.
    assign fa = biased ? r_set.nx : r_set.nx - 1'b1;
    assign fb = biased ? r_set.ny : r_set.ny - 1'b1;
    assign fc = incomplete ? r_set.nx - 1'b1 : r_set.ny;

    assign sat_hi = (r_diff > STAT_MAX);
    assign sat_lo = (r_diff < STAT_MIN);

    assign o_pop = (r_state == B_IDLE) && !i_empty;

    always_comb begin
        o_div_req.start = r_div_start;
        case (r_state)
            B_DIV_B: begin
                o_div_req.numer = r_num_b;
                o_div_req.denom = r_den_b;
            end
            B_DIV_C: begin
                o_div_req.numer = r_num_c;
                o_div_req.denom = r_den_c;
            end
            default: begin
                o_div_req.numer = r_num_a;
                o_div_req.denom = r_den_a;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_div_start <= 1'b0;
            o_valid     <= 1'b0;
            o_saturated <= 1'b0;
        end else begin
            r_div_start <= (r_state == B_NUM) ||
                           (((r_state == B_DIV_A) || (r_state == B_DIV_B)) &&
                            i_div_rsp.done);
            o_valid     <= (r_state == B_SAT);
            o_saturated <= (r_state == B_SAT) && (sat_hi || sat_lo);
            case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_set   <= i_set;
                        r_state <= B_PREP;
                    end
                end
                B_PREP: begin
                    r_ta    <= r_set.sums.first_block - r_set.sums.first_diag;
                    r_tb    <= r_set.sums.second_block - r_set.sums.second_diag;
                    r_tc    <= r_set.sums.cross_block - r_set.sums.cross_diag;
                    r_den_a <= DW'(r_set.nx) * DW'(fa);
                    r_den_b <= DW'(r_set.ny) * DW'(fb);
                    r_den_c <= DW'(r_set.nx) * DW'(fc);
                    r_state <= B_NUM;
                end
                B_NUM: begin
                    r_num_a     <= {r_ta[W-2:0], 1'b0} +
                                   (biased ? r_set.sums.first_diag : '0);
                    r_num_b     <= {r_tb[W-2:0], 1'b0} +
                                   (biased ? r_set.sums.second_diag : '0);
                    r_num_c     <= incomplete ? r_tc : r_set.sums.cross_block;
                    r_state     <= B_DIV_A;
                end
                B_DIV_A: begin
                    if (i_div_rsp.done) begin
                        r_qa        <= i_div_rsp.quot;
                        r_state     <= B_DIV_B;
                    end
                end
                B_DIV_B: begin
                    if (i_div_rsp.done) begin
                        r_qb        <= i_div_rsp.quot;
                        r_state     <= B_DIV_C;
                    end
                end
                B_DIV_C: begin
                    if (i_div_rsp.done) begin
                        r_qc    <= i_div_rsp.quot;
                        r_state <= B_SUM;
                    end
                end
                B_SUM: begin
                    r_sum   <= {r_qa[W-1], r_qa} + {r_qb[W-1], r_qb};
                    r_state <= B_DIFF;
                end
                B_DIFF: begin
                    // Quotients stay within 2^62, so doubling the cross term is exact.
                    r_diff  <= {r_sum[W], r_sum} - {r_qc[W-1], r_qc, 1'b0};
                    r_state <= B_SAT;
                end
                B_SAT: begin
                    if (sat_hi) begin
                        o_statistic <= SAT_POS;
                    end else if (sat_lo) begin
                        o_statistic <= SAT_NEG;
                    end else begin
                        o_statistic <= r_diff[SW-1:0];
                    end
                    r_state <= B_IDLE;
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

endmodule

### hdl/mmd_statistic_accumulator.sv
// Kernel entries are taken one per clock while busy is low; each final entry closes a set,
// whose six sums go into a two-set queue while accumulation of the next set goes on at full
// rate. The back end normalizes one set at a time with a single shared radix-2 divider that
// runs the three 64-bit divisions one after another, so on average sets can close no faster
// than the back end finishes them. busy rises only while two closed sets are waiting for the
// back end. The result is shown on o_statistic and o_saturated for exactly one cycle with
// o_valid high; the receiver cannot stall it. Configuration writes take effect at once and
// belong between sets.
module mmd_statistic_accumulator #(
    parameter int unsigned MAX_SAMPLES = mmd_pkg::MAX_SAMPLES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [mmd_pkg::KV_W-1:0]     i_kernel_value,
    input  logic [mmd_pkg::COUNT_W-1:0]         i_row_position,
    input  logic [mmd_pkg::COUNT_W-1:0]         i_col_position,
    input  logic                                i_final_entry,
    input  logic                                i_cfg_we,
    input  logic [mmd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mmd_pkg::COUNT_W-1:0]         i_cfg_data,
    output logic                                o_valid,
    output logic signed [mmd_pkg::STAT_W-1:0]   o_statistic,
    output logic                                o_saturated
);

    logic [mmd_pkg::COUNT_W-1:0] r_first_count;
    logic [mmd_pkg::COUNT_W-1:0] r_second_count;
    logic [mmd_pkg::MODE_W-1:0]  r_statistic_mode;

    logic              push;
    logic              pop;
    logic              empty;
    mmd_pkg::t_set     wr_set;
    mmd_pkg::t_set     rd_set;
    mmd_pkg::t_div_req div_req;
    mmd_pkg::t_div_rsp div_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_count    <= mmd_pkg::COUNT_RESET;
            r_second_count   <= mmd_pkg::COUNT_RESET;
            r_statistic_mode <= mmd_pkg::MODE_BIASED;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mmd_pkg::REG_FIRST_COUNT: begin
                    r_first_count <= i_cfg_data;
                end
                mmd_pkg::REG_SECOND_COUNT: begin
                    r_second_count <= i_cfg_data;
                end
                mmd_pkg::REG_STATISTIC_MODE: begin
                    r_statistic_mode <= i_cfg_data[mmd_pkg::MODE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    mmd_front #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .o_busy         (busy),
        .i_kernel_value (i_kernel_value),
        .i_row_position (i_row_position),
        .i_col_position (i_col_position),
        .i_final_entry  (i_final_entry),
        .i_first_count  (r_first_count),
        .i_second_count (r_second_count),
        .i_mode         (r_statistic_mode),
        .o_push         (push),
        .o_set          (wr_set),
        .i_pop          (pop)
    );

    mmd_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_wr_data (wr_set),
        .i_pop     (pop),
        .o_rd_data (rd_set),
        .o_empty   (empty)
    );

    mmd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_set       (rd_set),
        .o_pop       (pop),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp),
        .o_valid     (o_valid),
        .o_statistic (o_statistic),
        .o_saturated (o_saturated)
    );

    mmd_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

endmodule

### hdl/mmd_checker.sv
module mmd_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              busy,
    input logic                              o_valid,
    input logic signed [mmd_pkg::STAT_W-1:0] o_statistic,
    input logic                              o_saturated
);

    localparam logic [mmd_pkg::STAT_W-1:0] SAT_POS = {1'b0, {(mmd_pkg::STAT_W - 1){1'b1}}};
    localparam logic [mmd_pkg::STAT_W-1:0] SAT_NEG = {1'b1, {(mmd_pkg::STAT_W - 1){1'b0}}};

    // Reset leaves the block able to take a transaction and with no result pending.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_valid)
        else $error("busy or result strobe right after reset");

    a_sat_with_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_saturated |-> o_valid)
        else $error("saturation flag without a result");

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
            (o_statistic == SAT_POS || o_statistic == SAT_NEG))
        else $error("saturated result is not at a range limit");

    // The normalizer works on one set at a time and returns to idle before taking the next, so two results never touch.
    a_result_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("results on consecutive cycles");

endmodule

bind mmd_statistic_accumulator mmd_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_statistic (o_statistic),
    .o_saturated (o_saturated)
);
